>>> src/whtf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whtf_pkg
// Shared sizes, command and register codes and stage types for the weighted
// Hamming threshold filter.
// ----------------------------------------------------------------------------
package whtf_pkg;

    localparam int CHUNK_BITS  = 8;
    localparam int CHUNK_COUNT = 64;
    localparam int MAX_ENTRIES = 1048576;

    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 8;
    localparam int VALUE_W  = 8;
    localparam int WEIGHT_W = 8;
    localparam int SUM_W    = 14;
    localparam int INDEX_W  = 24;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 1;

    localparam int TABLE_DEPTH = 1 << CHUNK_BITS;
    localparam int QIDX_W      = $clog2(CHUNK_COUNT);
    localparam int ENTRY_W     = $clog2(MAX_ENTRIES);
    localparam int KEPT_W      = $clog2(MAX_ENTRIES + 1);

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [CMD_W-1:0] CMD_TABLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DB    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_INDEX     = 1'd1;

    // database chunk after the query read
    typedef struct packed {
        logic                  in_range;
        logic                  last_chunk;
        logic                  last_entry;
        logic [CHUNK_BITS-1:0] chunk;
    } t_s1;

    // database chunk after the weight read
    typedef struct packed {
        logic in_range;
        logic last_chunk;
        logic last_entry;
    } t_s2;

    typedef struct packed {
        logic                  we;
        logic [CHUNK_BITS-1:0] addr;
        logic [WEIGHT_W-1:0]   data;
    } t_tbl_wr;

    typedef struct packed {
        logic [SUM_W-1:0]   distance_limit;
        logic [INDEX_W-1:0] base_index;
    } t_cfg;

endpackage

>>> src/whtf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whtf_front
// Input register and query code memory: store query chunks, read the query
// chunk for each database chunk.
// ----------------------------------------------------------------------------
module whtf_front
    import whtf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_take,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [SLOT_W-1:0]     i_slot,
    input  logic [VALUE_W-1:0]    i_value,
    input  logic                  i_last_chunk,
    input  logic                  i_last_entry,
    output logic                  o_valid,
    output t_s1                   o_s1,
    output logic [CHUNK_BITS-1:0] o_query
);

    logic [CHUNK_BITS-1:0] r_query_mem [CHUNK_COUNT];
    logic [CHUNK_BITS-1:0] r_query;
    logic                  r_valid;
    t_s1                   r_s1;
    logic                  in_range;

    assign in_range = ({1'b0, i_slot} < (SLOT_W + 1)'(CHUNK_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_take && (i_cmd == CMD_DB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1.in_range   <= in_range;
            r_s1.last_chunk <= i_last_chunk;
            r_s1.last_entry <= i_last_entry;
            r_s1.chunk      <= CHUNK_BITS'(i_value);
            r_query         <= r_query_mem[i_slot[QIDX_W-1:0]];
        end
    end

    // query write: out-of-range positions are dropped
    always_ff @(posedge i_clk) begin
        if (i_take && (i_cmd == CMD_QUERY) && in_range) begin
            r_query_mem[i_slot[QIDX_W-1:0]] <= CHUNK_BITS'(i_value);
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;
    assign o_query = r_query;

endmodule

>>> src/whtf_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whtf_lookup
// Weight table: XOR the chunk with its query chunk and read the weight.
// ----------------------------------------------------------------------------
module whtf_lookup
    import whtf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  t_tbl_wr               i_wr,
    input  logic                  i_valid,
    input  t_s1                   i_s1,
    input  logic [CHUNK_BITS-1:0] i_query,
    output logic                  o_valid,
    output t_s2                   o_s2,
    output logic [WEIGHT_W-1:0]   o_weight
);

    logic [WEIGHT_W-1:0] r_table [TABLE_DEPTH];
    logic [WEIGHT_W-1:0] r_weight;
    logic                r_valid;
    t_s2                 r_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s2.in_range   <= i_s1.in_range;
            r_s2.last_chunk <= i_s1.last_chunk;
            r_s2.last_entry <= i_s1.last_entry;
            r_weight        <= r_table[i_s1.chunk ^ i_query];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_table[i_wr.addr] <= i_wr.data;
        end
    end

    assign o_valid  = r_valid;
    assign o_s2     = r_s2;
    assign o_weight = r_weight;

endmodule

>>> src/whtf_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whtf_accum
// Saturating distance sum, entry and kept counters, threshold test and the
// result register.
// ----------------------------------------------------------------------------
module whtf_accum
    import whtf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  t_cfg                i_cfg,
    input  logic                i_valid,
    input  t_s2                 i_s2,
    input  logic [WEIGHT_W-1:0] i_weight,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [INDEX_W-1:0]  o_entry_index,
    output logic [SUM_W-1:0]    o_distance,
    output logic [KEPT_W-1:0]   o_kept_count,
    output logic                o_pass_done
);

    logic [SUM_W-1:0]   r_sum;
    logic [ENTRY_W-1:0] r_entry;
    logic [KEPT_W-1:0]  r_kept;
    logic               r_out_valid;
    logic [INDEX_W-1:0] r_entry_index;
    logic [SUM_W-1:0]   r_distance;
    logic [KEPT_W-1:0]  r_kept_count;
    logic               r_pass_done;

    logic [SUM_W:0]     n_add;
    logic [SUM_W-1:0]   n_sum;
    logic               keep;
    logic               step;
    logic               entry_end;
    logic [KEPT_W-1:0]  n_kept;
    logic [ENTRY_W-1:0] n_entry;

    assign step      = i_valid && i_adv;
    assign entry_end = step && i_s2.last_chunk;

    always_comb begin
        n_add = {1'b0, r_sum} + (i_s2.in_range ? (SUM_W + 1)'(i_weight) : '0);
        n_sum = (n_add > {1'b0, SUM_MAX}) ? SUM_MAX : n_add[SUM_W-1:0];
        keep  = (n_sum < i_cfg.distance_limit);
        // saturate kept count at the pass capacity
        n_kept = (keep && (r_kept < KEPT_W'(MAX_ENTRIES))) ? r_kept + 1'b1 : r_kept;
        n_entry = (r_entry == ENTRY_W'(MAX_ENTRIES - 1)) ? '0 : r_entry + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_entry     <= '0;
            r_kept      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_adv) begin
                r_out_valid <= i_valid && i_s2.last_chunk && keep;
            end
            if (step) begin
                if (i_s2.last_chunk) begin
                    r_sum <= '0;
                    if (i_s2.last_entry) begin
                        r_entry <= '0;
                        r_kept  <= '0;
                    end else begin
                        r_entry <= n_entry;
                        r_kept  <= n_kept;
                    end
                end else begin
                    r_sum <= n_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_entry_index <= i_cfg.base_index + INDEX_W'(r_entry);
            r_distance    <= n_sum;
            r_kept_count  <= n_kept;
            r_pass_done   <= i_s2.last_entry;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_index = r_entry_index;
    assign o_distance    = r_distance;
    assign o_kept_count  = r_kept_count;
    assign o_pass_done   = r_pass_done;

    a_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_distance < i_cfg.distance_limit))
        else $error("result distance not below limit");

    a_kept_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_kept_count != '0))
        else $error("result with zero kept count");

    a_pass_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (entry_end && i_s2.last_entry) |=> (r_entry == '0 && r_kept == '0))
        else $error("counters not cleared at end of pass");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_distance)))
        else $error("stalled result lost");

endmodule

>>> src/weighted_hamming_threshold_filter.sv
`timescale 1ns / 1ps
// Path: a database chunk that ends a kept entry passes the query read, the
//   weight read, and the sum and test registers before its result shows.
// Throughput: one request per cycle unless full and stalled; the three stages
//   advance independently, so bubbles close up while the output stalls.
// Reset: synchronous active low; clears stage valids, sum and counters and sets
//   the limit to its maximum. Weight table and query code hold no reset value.
// ----------------------------------------------------------------------------
// weighted_hamming_threshold_filter
// Binary-code retrieval filter: table-weighted Hamming distance per database
// entry, kept when strictly below a programmable limit.
// ----------------------------------------------------------------------------
module weighted_hamming_threshold_filter
    import whtf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [SLOT_W-1:0]    i_slot,
    input  logic [VALUE_W-1:0]   i_value,
    input  logic                 i_last_chunk,
    input  logic                 i_last_entry,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [INDEX_W-1:0]   o_entry_index,
    output logic [SUM_W-1:0]     o_distance,
    output logic [KEPT_W-1:0]    o_kept_count,
    output logic                 o_pass_done
);

    t_cfg                  r_cfg;
    logic                  adv_s1;
    logic                  adv_s2;
    logic                  adv_out;
    logic                  take;
    logic                  s1_valid;
    t_s1                   s1;
    logic [CHUNK_BITS-1:0] query;
    logic                  s2_valid;
    t_s2                   s2;
    logic [WEIGHT_W-1:0]   weight;
    t_tbl_wr               tbl_wr;

    // Config taken when written; user must write only while idle, unenforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.distance_limit <= SUM_MAX;
            r_cfg.base_index     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DISTANCE_LIMIT: r_cfg.distance_limit <= i_cfg_data[SUM_W-1:0];
                CFG_BASE_INDEX:     r_cfg.base_index     <= i_cfg_data[INDEX_W-1:0];
                default: ;
            endcase
        end
    end

    // Each stage advances when it is empty or the stage after it moves on.
    assign adv_out    = !o_out_valid || !i_out_stall;
    assign adv_s2     = !s2_valid || adv_out;
    assign adv_s1     = !s1_valid || adv_s2;
    assign o_in_stall = !adv_s1;
    assign take       = i_in_valid && adv_s1;

    // Table writes land at the accept edge; later reads see them, earlier
    // ones read before the write.
    always_comb begin
        tbl_wr.we   = take && (i_cmd == CMD_TABLE);
        tbl_wr.addr = CHUNK_BITS'(i_slot);
        tbl_wr.data = WEIGHT_W'(i_value);
    end

    whtf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv_s1),
        .i_take       (take),
        .i_cmd        (i_cmd),
        .i_slot       (i_slot),
        .i_value      (i_value),
        .i_last_chunk (i_last_chunk),
        .i_last_entry (i_last_entry),
        .o_valid      (s1_valid),
        .o_s1         (s1),
        .o_query      (query)
    );

    whtf_lookup u_lookup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv_s2),
        .i_wr     (tbl_wr),
        .i_valid  (s1_valid),
        .i_s1     (s1),
        .i_query  (query),
        .o_valid  (s2_valid),
        .o_s2     (s2),
        .o_weight (weight)
    );

    whtf_accum u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv_out),
        .i_cfg         (r_cfg),
        .i_valid       (s2_valid),
        .i_s2          (s2),
        .i_weight      (weight),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_entry_index (o_entry_index),
        .o_distance    (o_distance),
        .o_kept_count  (o_kept_count),
        .o_pass_done   (o_pass_done)
    );

    a_no_take_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && s2_valid && o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("request accepted into a full pipeline");

    a_s2_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_valid && !adv_s2) |=> s2_valid)
        else $error("stalled chunk dropped");

    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && !adv_s1) |=> s1_valid)
        else $error("stalled query read dropped");

endmodule
